// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge while reset is released.
`define ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rstn, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: rtl/mbbt_pkg.sv
// ---------------------------------------------------------------------------
// mbbt_pkg
// Types, widths and constants of the bars/beats/ticks transport clock.
// ---------------------------------------------------------------------------
package mbbt_pkg;

    // Field widths.
    localparam int BAR_W    = 40;
    localparam int BEAT_W   = 7;
    localparam int TICK_W   = 16;
    localparam int TEMPO_W  = 18;
    localparam int RATE_W   = 18;
    localparam int FRAME_W  = 32;
    localparam int PERIOD_W = 16;

    // Stream word widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 104;

    // Configuration port.
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] IDX_BAR_BEATS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_BEAT_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_TEMPO_Q8    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_SAMPLE_RATE = 2'd3;

    // Register reset values.
    localparam logic [BEAT_W-1:0]  RST_BAR_BEATS   = 7'd4;
    localparam logic [TICK_W-1:0]  RST_BEAT_TICKS  = 16'd1920;
    localparam logic [TEMPO_W-1:0] RST_TEMPO_Q8    = 18'd30720;
    localparam logic [RATE_W-1:0]  RST_SAMPLE_RATE = 18'd48000;

    // Shared divider: dividend covers every tick total, divisor covers
    // sample_rate * 15360.
    localparam int DVD_W = 54;
    localparam int DSR_W = 32;
    localparam int CNT_W = 6;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_P,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MUL_QT,
        S_MUL_RT,
        S_MUL_BS1,
        S_MUL_BS2,
        S_FIN
    } seq_state_t;

    // Which division the shared divider is working on.
    typedef enum logic [1:0] {
        DOP_P,
        DOP_RT,
        DOP_TICK,
        DOP_BEAT
    } div_op_t;

endpackage

// File: rtl/mbbt_divider.sv
// ---------------------------------------------------------------------------
// mbbt_divider
// Restoring unsigned divider, one quotient bit per clock cycle.
// ---------------------------------------------------------------------------
module mbbt_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [mbbt_pkg::DVD_W-1:0] dividend,
    input  logic [mbbt_pkg::DSR_W-1:0] divisor,
    output logic                       busy,
    output logic [mbbt_pkg::DVD_W-1:0] quotient,
    output logic [mbbt_pkg::DSR_W-1:0] remainder
);

    logic                       busy_reg, busy_next;
    logic [mbbt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [mbbt_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [mbbt_pkg::DSR_W-1:0] rem_reg, rem_next;
    logic [mbbt_pkg::DSR_W-1:0] dsr_reg, dsr_next;
    logic [mbbt_pkg::DSR_W:0]   partial;
    logic [mbbt_pkg::DSR_W:0]   trial;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign partial = {rem_reg, quo_reg[mbbt_pkg::DVD_W-1]};
    assign trial   = partial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = mbbt_pkg::CNT_W'(mbbt_pkg::DVD_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial[mbbt_pkg::DSR_W]) begin
                rem_next = partial[mbbt_pkg::DSR_W-1:0];
                quo_next = {quo_reg[mbbt_pkg::DVD_W-2:0], 1'b0};
            end else begin
                rem_next = trial[mbbt_pkg::DSR_W-1:0];
                quo_next = {quo_reg[mbbt_pkg::DVD_W-2:0], 1'b1};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/musical_bar_beat_tick_counter_top.sv
// ---------------------------------------------------------------------------
// musical_bar_beat_tick_counter_top
// Musical transport clock giving bar, beat, tick and bar-start tick.
// ---------------------------------------------------------------------------
// Usage:
//   The slave stream takes one word per audio period: tuser carries the
//   reposition flag, tdata the absolute frame and the period length.
//   The master stream returns one word per input word with the position
//   after that period. Configuration registers are written through the
//   plain write port while the block is idle; any write forces the next
//   word to rebuild the position from its frame number.
//   Each word is worked by one shared 40x18 multiplier and one shared
//   restoring divider under a small sequencer. A division runs a start
//   step, the quotient bits one by one and a hand-off; four of them plus
//   five multiply steps and the output step produce the result. s_tready
//   is low from acceptance until the sequencer is back in idle, so a new
//   word is not taken before the last one has been worked through.
//   The result sits in an output register. A new word is accepted while
//   it waits; if the receiver still stalls when the next result is done,
//   the sequencer holds in its last step until the register frees.
//   Reset restores the register defaults, sets the position to bar 1,
//   beat 1, tick 0 and marks a rebuild for the first word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module musical_bar_beat_tick_counter_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [mbbt_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [mbbt_pkg::CFG_W-1:0]     cfg_wdata,
    // Input stream.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: frame_position[31:0], period_frames[47:32].
    input  logic [mbbt_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: reposition[0].
    input  logic                           s_tuser,
    // Result stream.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: bar_number[39:0], beat_number[46:40], tick_number[62:47],
    // bar_start_ticks[102:63], zero pad[103].
    output logic [mbbt_pkg::M_TDATA_W-1:0] m_tdata
);

    // Configuration registers.
    logic [mbbt_pkg::BEAT_W-1:0]   bpb_reg;
    logic [mbbt_pkg::TICK_W-1:0]   tpb_reg;
    logic [mbbt_pkg::TEMPO_W-1:0]  tempo_reg;
    logic [mbbt_pkg::RATE_W-1:0]   rate_reg;
    logic                          pend_reg;

    // Sequencer.
    mbbt_pkg::seq_state_t          state_reg, state_next;
    mbbt_pkg::div_op_t             dop_reg, dop_next;

    // Latched input word.
    logic                          repos_reg;
    logic [mbbt_pkg::FRAME_W-1:0]  frame_reg;
    logic [mbbt_pkg::PERIOD_W-1:0] period_reg;

    // Work registers.
    logic [mbbt_pkg::DVD_W-1:0]    dvd_reg, dvd_next;
    logic [mbbt_pkg::DVD_W-1:0]    acc_reg, acc_next;
    logic [mbbt_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [mbbt_pkg::BAR_W-1:0]    bs_reg, bs_next;

    // Position state.
    logic [mbbt_pkg::TICK_W-1:0]   cur_tick_reg;
    logic [mbbt_pkg::BEAT_W-1:0]   cur_beat_reg;
    logic [mbbt_pkg::BAR_W-1:0]    cur_bar_reg;
    logic [mbbt_pkg::BAR_W-1:0]    cur_bs_reg;
    logic [mbbt_pkg::BAR_W-1:0]    bar_new;
    logic [mbbt_pkg::BAR_W-1:0]    bs_new;
    logic [mbbt_pkg::BEAT_W-1:0]   beat_new;

    // Output register.
    logic                          m_tvalid_reg;
    logic [mbbt_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // Control strobes.
    logic                          in_accept;
    logic                          fin_commit;

    // Shared arithmetic.
    logic [mbbt_pkg::MUL_A_W-1:0]  mul_a;
    logic [mbbt_pkg::MUL_B_W-1:0]  mul_b;
    logic [mbbt_pkg::MUL_P_W-1:0]  mul_p;
    logic                          div_start;
    logic                          div_busy;
    logic [mbbt_pkg::DSR_W-1:0]    div_dsr;
    logic [mbbt_pkg::DVD_W-1:0]    div_quo;
    logic [mbbt_pkg::DSR_W-1:0]    div_rem;

    // Zero-guarded settings and the tempo divisor sample_rate * 15360.
    logic [mbbt_pkg::BEAT_W-1:0]   bpb_eff;
    logic [mbbt_pkg::TICK_W-1:0]   tpb_eff;
    logic [mbbt_pkg::RATE_W-1:0]   rate_eff;
    logic [mbbt_pkg::DSR_W-1:0]    tempo_dsr;
    logic [mbbt_pkg::BEAT_W-1:0]   zbase;

    assign bpb_eff  = (bpb_reg == '0) ? mbbt_pkg::BEAT_W'(1) : bpb_reg;
    assign tpb_eff  = (tpb_reg == '0) ? mbbt_pkg::TICK_W'(1) : tpb_reg;
    assign rate_eff = (rate_reg == '0) ? mbbt_pkg::RATE_W'(1) : rate_reg;
    assign tempo_dsr = ({rate_eff, 14'd0} - {4'd0, rate_eff, 10'd0});
    assign zbase    = (cur_beat_reg == '0) ? '0 : cur_beat_reg - 1'b1;

    assign in_accept  = s_tvalid && s_tready;
    assign fin_commit = (state_reg == mbbt_pkg::S_FIN) && (!m_tvalid_reg || m_tready);
    assign s_tready   = (state_reg == mbbt_pkg::S_IDLE);
    assign div_start  = (state_reg == mbbt_pkg::S_DIV_GO);
    assign mul_p      = mul_a * mul_b;

    // Divisor for the current division.
    always_comb begin
        case (dop_reg)
            mbbt_pkg::DOP_P:    div_dsr = tempo_dsr;
            mbbt_pkg::DOP_RT:   div_dsr = tempo_dsr;
            mbbt_pkg::DOP_TICK: div_dsr = {16'd0, tpb_eff};
            mbbt_pkg::DOP_BEAT: div_dsr = {25'd0, bpb_eff};
            default:            div_dsr = tempo_dsr;
        endcase
    end

    mbbt_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (dvd_reg),
        .divisor   (div_dsr),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        dop_next   = dop_reg;
        case (state_reg)
            mbbt_pkg::S_IDLE: begin
                if (in_accept) begin
                    state_next = mbbt_pkg::S_MUL_P;
                end
            end
            mbbt_pkg::S_MUL_P: begin
                state_next = mbbt_pkg::S_DIV_GO;
                dop_next   = mbbt_pkg::DOP_P;
            end
            mbbt_pkg::S_DIV_GO: begin
                state_next = mbbt_pkg::S_DIV_WAIT;
            end
            mbbt_pkg::S_DIV_WAIT: begin
                if (!div_busy) begin
                    case (dop_reg)
                        mbbt_pkg::DOP_P: begin
                            state_next = mbbt_pkg::S_MUL_QT;
                        end
                        mbbt_pkg::DOP_RT: begin
                            state_next = mbbt_pkg::S_DIV_GO;
                            dop_next   = mbbt_pkg::DOP_TICK;
                        end
                        mbbt_pkg::DOP_TICK: begin
                            state_next = mbbt_pkg::S_DIV_GO;
                            dop_next   = mbbt_pkg::DOP_BEAT;
                        end
                        default: begin
                            state_next = mbbt_pkg::S_MUL_BS1;
                        end
                    endcase
                end
            end
            mbbt_pkg::S_MUL_QT: begin
                state_next = mbbt_pkg::S_MUL_RT;
            end
            mbbt_pkg::S_MUL_RT: begin
                state_next = mbbt_pkg::S_DIV_GO;
                dop_next   = mbbt_pkg::DOP_RT;
            end
            mbbt_pkg::S_MUL_BS1: begin
                state_next = mbbt_pkg::S_MUL_BS2;
            end
            mbbt_pkg::S_MUL_BS2: begin
                state_next = mbbt_pkg::S_FIN;
            end
            mbbt_pkg::S_FIN: begin
                if (fin_commit) begin
                    state_next = mbbt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mbbt_pkg::S_IDLE;
            end
        endcase
    end

    // Multiplier operands and work register updates per step.
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        dvd_next  = dvd_reg;
        acc_next  = acc_reg;
        tick_next = tick_reg;
        bs_next   = bs_reg;
        case (state_reg)
            mbbt_pkg::S_MUL_P: begin
                // Scaled frames: frame or period times tempo.
                mul_a    = repos_reg ? {8'd0, frame_reg} : {24'd0, period_reg};
                mul_b    = tempo_reg;
                dvd_next = mul_p[mbbt_pkg::DVD_W-1:0];
            end
            mbbt_pkg::S_MUL_QT: begin
                // Whole part of the tick count: quotient times ticks per beat.
                mul_a    = div_quo[mbbt_pkg::MUL_A_W-1:0];
                mul_b    = {2'd0, tpb_eff};
                acc_next = mul_p[mbbt_pkg::DVD_W-1:0];
            end
            mbbt_pkg::S_MUL_RT: begin
                // Fraction part: remainder times ticks per beat, divided next.
                mul_a    = {8'd0, div_rem};
                mul_b    = {2'd0, tpb_eff};
                dvd_next = mul_p[mbbt_pkg::DVD_W-1:0];
            end
            mbbt_pkg::S_DIV_WAIT: begin
                if (!div_busy) begin
                    case (dop_reg)
                        mbbt_pkg::DOP_RT: begin
                            // Tick total, added to the current tick unless rebuilt.
                            dvd_next = acc_reg + div_quo
                                     + (repos_reg ? '0 : {38'd0, cur_tick_reg});
                        end
                        mbbt_pkg::DOP_TICK: begin
                            tick_next = div_rem[mbbt_pkg::TICK_W-1:0];
                            dvd_next  = repos_reg ? div_quo : div_quo + {47'd0, zbase};
                        end
                        default: begin
                            dvd_next = dvd_reg;
                        end
                    endcase
                end
            end
            mbbt_pkg::S_MUL_BS1: begin
                // Bars times beats per bar, modulo the bar width.
                mul_a   = div_quo[mbbt_pkg::BAR_W-1:0];
                mul_b   = {11'd0, bpb_eff};
                bs_next = mul_p[mbbt_pkg::BAR_W-1:0];
            end
            mbbt_pkg::S_MUL_BS2: begin
                // Then times ticks per beat: ticks spanned by those bars.
                mul_a   = bs_reg;
                mul_b   = {2'd0, tpb_eff};
                bs_next = mul_p[mbbt_pkg::BAR_W-1:0];
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // New position from the last division (still held in the divider).
    assign beat_new = div_rem[mbbt_pkg::BEAT_W-1:0] + 1'b1;
    assign bar_new  = repos_reg ? div_quo[mbbt_pkg::BAR_W-1:0] + 1'b1
                                : cur_bar_reg + div_quo[mbbt_pkg::BAR_W-1:0];
    assign bs_new   = repos_reg ? bs_reg : cur_bs_reg + bs_reg;

    // Control, configuration and position state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mbbt_pkg::S_IDLE;
            dop_reg      <= mbbt_pkg::DOP_P;
            bpb_reg      <= mbbt_pkg::RST_BAR_BEATS;
            tpb_reg      <= mbbt_pkg::RST_BEAT_TICKS;
            tempo_reg    <= mbbt_pkg::RST_TEMPO_Q8;
            rate_reg     <= mbbt_pkg::RST_SAMPLE_RATE;
            pend_reg     <= 1'b1;
            cur_tick_reg <= '0;
            cur_beat_reg <= mbbt_pkg::BEAT_W'(1);
            cur_bar_reg  <= mbbt_pkg::BAR_W'(1);
            cur_bs_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            dop_reg   <= dop_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    mbbt_pkg::IDX_BAR_BEATS:   bpb_reg   <= cfg_wdata[mbbt_pkg::BEAT_W-1:0];
                    mbbt_pkg::IDX_BEAT_TICKS:  tpb_reg   <= cfg_wdata[mbbt_pkg::TICK_W-1:0];
                    mbbt_pkg::IDX_TEMPO_Q8:    tempo_reg <= cfg_wdata;
                    mbbt_pkg::IDX_SAMPLE_RATE: rate_reg  <= cfg_wdata;
                    default:                   rate_reg  <= rate_reg;
                endcase
                pend_reg <= 1'b1;
            end else if (in_accept) begin
                pend_reg <= 1'b0;
            end
            if (fin_commit) begin
                cur_tick_reg <= tick_reg;
                cur_beat_reg <= beat_new;
                cur_bar_reg  <= bar_new;
                cur_bs_reg   <= bs_new;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        acc_reg  <= acc_next;
        tick_reg <= tick_next;
        bs_reg   <= bs_next;
        if (in_accept) begin
            repos_reg  <= s_tuser || pend_reg;
            frame_reg  <= s_tdata[mbbt_pkg::FRAME_W-1:0];
            period_reg <= s_tdata[mbbt_pkg::S_TDATA_W-1:mbbt_pkg::FRAME_W];
        end
        if (fin_commit) begin
            m_tdata_reg <= {1'b0, bs_new, tick_reg, beat_new, bar_new};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An accepted word always starts with the scaling multiply.
    `ASSERT_RST(a_accept_starts, aclk, aresetn,
        in_accept |=> state_reg == mbbt_pkg::S_MUL_P)
    // The divider is never restarted while it is still working.
    `ASSERT_RST(a_div_no_restart, aclk, aresetn, div_start |-> !div_busy)
    // A result appears only as the last sequencer step completes.
    `ASSERT_RST(a_result_from_fin, aclk, aresetn,
        $rose(m_tvalid_reg) |-> $past(state_reg) == mbbt_pkg::S_FIN)
    // Every configuration write forces a rebuild of the next word.
    `ASSERT_RST(a_cfg_sets_pending, aclk, aresetn, cfg_wr_en |=> pend_reg)

endmodule
